// ===== hdl/arbb_pkg.sv =====
package arbb_pkg;

  localparam int COEF_W = 32;
  localparam int DIM_W  = 31;
  localparam int CRD_W  = COEF_W + 1;
  localparam int PROD_W = 64;
  localparam int SUM_W  = 50;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(65536);
  localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

  typedef enum logic {
    OP_POINT = 1'b0,
    OP_RECT  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_XX = 3'd0,
    CFG_XY = 3'd1,
    CFG_XT = 3'd2,
    CFG_YX = 3'd3,
    CFG_YY = 3'd4,
    CFG_YT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    op_e                      op;
    logic signed [COEF_W-1:0] in_x;
    logic signed [COEF_W-1:0] in_y;
    logic [DIM_W-1:0]         in_w;
    logic [DIM_W-1:0]         in_h;
  } in_word_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] out_x;
    logic signed [COEF_W-1:0] out_y;
    logic [DIM_W-1:0]         out_w;
    logic [DIM_W-1:0]         out_h;
  } out_word_t;

endpackage

// ===== hdl/arbb_ifs.sv =====
interface arbb_in_if;
  logic               valid;
  logic               ready;
  arbb_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface arbb_out_if;
  logic                valid;
  logic                ready;
  arbb_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/affine_rect_bounding_box_core.sv =====
// Applies a programmable 2D affine transform (six signed Q16.16 coefficients,
// identity after reset) to a point or to an axis-aligned rectangle, returning the
// transformed point or the bounding box of the four transformed corners. The core
// takes one word per clock while back-pressure allows, and passes each result through
// the input register, eight parallel 32x33 multiplier lanes, corner sums with
// rounding, min/max, then saturation into the output register. A stalled output
// holds its word while earlier stages keep filling their empty slots, so a new word
// is taken whenever any stage ahead has room. Coefficients should be written only
// while no word is in flight.
module affine_rect_bounding_box_core (
  input  logic                                clk,
  input  logic                                rst_n,
  arbb_in_if.sink                             in_if,
  arbb_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [arbb_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [arbb_pkg::COEF_W-1:0]         cfg_wdata
);
  import arbb_pkg::*;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [CRD_W-1:0]  crd_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [SUM_W:0]    diff_t;

  function automatic prod_t mul_q(coef_t c, crd_t v);
    logic signed [COEF_W+CRD_W-1:0] p;
    p = c * v;
    return p[PROD_W-1:0];
  endfunction

  // Rounded product is p[63:16] + p[15]; both carries fold into the corner sum.
  function automatic sum_t corner(prod_t pa, prod_t pb, coef_t t);
    sum_t a;
    sum_t b;
    a = SUM_W'($signed(pa[PROD_W-1:16]));
    b = SUM_W'($signed(pb[PROD_W-1:16]));
    return a + b + SUM_W'(t) + SUM_W'({1'b0, pa[15]}) + SUM_W'({1'b0, pb[15]});
  endfunction

  function automatic sum_t smin(sum_t a, sum_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic sum_t smax(sum_t a, sum_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coef_t sat_s32(sum_t v);
    if (v > SUM_W'(64'sd2147483647)) begin
      return coef_t'(32'h7fffffff);
    end else if (v < SUM_W'(-64'sd2147483648)) begin
      return coef_t'(32'h80000000);
    end
    return v[COEF_W-1:0];
  endfunction

  function automatic logic [DIM_W-1:0] sat_u31(diff_t v);
    if (v > (SUM_W+1)'(64'sd2147483647)) begin
      return {DIM_W{1'b1}};
    end
    return v[DIM_W-1:0];
  endfunction

  // Configuration registers
  coef_t coef_xx_r, coef_xy_r, coef_xt_r, coef_yx_r, coef_yy_r, coef_yt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_xx_r <= COEF_ONE;
      coef_xy_r <= COEF_ZERO;
      coef_xt_r <= COEF_ZERO;
      coef_yx_r <= COEF_ZERO;
      coef_yy_r <= COEF_ONE;
      coef_yt_r <= COEF_ZERO;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_XX: coef_xx_r <= cfg_wdata;
        CFG_XY: coef_xy_r <= cfg_wdata;
        CFG_XT: coef_xt_r <= cfg_wdata;
        CFG_YX: coef_yx_r <= cfg_wdata;
        CFG_YY: coef_yy_r <= cfg_wdata;
        CFG_YT: coef_yt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage occupancy and per-stage advance
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;
  logic in_fire, out_fire;

  assign en5 = !v5_r || out_if.ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_if.ready = en1 && rst_n;
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_if.valid && out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_if.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Stage 1: far corner coordinates. A point collapses all corners onto itself.
  logic rect1_nxt, rect1_r;
  crd_t x1_r, y1_r, xw1_nxt, yh1_nxt, xw1_r, yh1_r;

  assign rect1_nxt = (in_if.data.op == OP_RECT);
  assign xw1_nxt   = rect1_nxt ? crd_t'({in_if.data.in_x[COEF_W-1], in_if.data.in_x}
                                        + {2'b00, in_if.data.in_w})
                               : crd_t'(in_if.data.in_x);
  assign yh1_nxt   = rect1_nxt ? crd_t'({in_if.data.in_y[COEF_W-1], in_if.data.in_y}
                                        + {2'b00, in_if.data.in_h})
                               : crd_t'(in_if.data.in_y);

  always_ff @(posedge clk) begin
    if (en1) begin
      rect1_r <= rect1_nxt;
      x1_r    <= crd_t'(in_if.data.in_x);
      y1_r    <= crd_t'(in_if.data.in_y);
      xw1_r   <= xw1_nxt;
      yh1_r   <= yh1_nxt;
    end
  end

  // Stage 2: eight multiplier lanes; index 0 is the near edge, 1 the far edge.
  logic  rect2_r;
  prod_t pxx_r [2];
  prod_t pxy_r [2];
  prod_t pyx_r [2];
  prod_t pyy_r [2];

  always_ff @(posedge clk) begin
    if (en2) begin
      rect2_r  <= rect1_r;
      pxx_r[0] <= mul_q(coef_xx_r, x1_r);
      pxx_r[1] <= mul_q(coef_xx_r, xw1_r);
      pxy_r[0] <= mul_q(coef_xy_r, y1_r);
      pxy_r[1] <= mul_q(coef_xy_r, yh1_r);
      pyx_r[0] <= mul_q(coef_yx_r, x1_r);
      pyx_r[1] <= mul_q(coef_yx_r, xw1_r);
      pyy_r[0] <= mul_q(coef_yy_r, y1_r);
      pyy_r[1] <= mul_q(coef_yy_r, yh1_r);
    end
  end

  // Stage 3: corners (x,y), (x+w,y), (x,y+h), (x+w,y+h), exact and unsaturated.
  logic rect3_r;
  sum_t cx_r [4];
  sum_t cy_r [4];

  always_ff @(posedge clk) begin
    if (en3) begin
      rect3_r <= rect2_r;
      for (int i = 0; i < 4; i++) begin
        cx_r[i] <= corner(pxx_r[i % 2], pxy_r[i / 2], coef_xt_r);
        cy_r[i] <= corner(pyx_r[i % 2], pyy_r[i / 2], coef_yt_r);
      end
    end
  end

  // Stage 4: bounding box extremes
  logic rect4_r;
  sum_t minx4_r, maxx4_r, miny4_r, maxy4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      rect4_r <= rect3_r;
      minx4_r <= smin(smin(cx_r[0], cx_r[1]), smin(cx_r[2], cx_r[3]));
      maxx4_r <= smax(smax(cx_r[0], cx_r[1]), smax(cx_r[2], cx_r[3]));
      miny4_r <= smin(smin(cy_r[0], cy_r[1]), smin(cy_r[2], cy_r[3]));
      maxy4_r <= smax(smax(cy_r[0], cy_r[1]), smax(cy_r[2], cy_r[3]));
    end
  end

  // Stage 5: saturation into the output register
  logic      rect5_r;
  out_word_t out5_nxt, out5_r;
  diff_t     dx, dy;

  assign dx = diff_t'(maxx4_r) - diff_t'(minx4_r);
  assign dy = diff_t'(maxy4_r) - diff_t'(miny4_r);

  always_comb begin
    out5_nxt.out_x = sat_s32(minx4_r);
    out5_nxt.out_y = sat_s32(miny4_r);
    out5_nxt.out_w = sat_u31(dx);
    out5_nxt.out_h = sat_u31(dy);
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      rect5_r <= rect4_r;
      out5_r  <= out5_nxt;
    end
  end

  assign out_if.valid = v5_r;
  assign out_if.data  = out5_r;

  logic [4:0] occ;
  assign occ = {v5_r, v4_r, v3_r, v2_r, v1_r};

  // Words are neither dropped nor duplicated inside the pipeline.
  a_occ_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !out_fire) |=> ($countones(occ) == $past($countones(occ)) + 1))
    else $error("pipeline occupancy did not grow on accept");

  a_occ_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_fire && out_fire) |=> ($countones(occ) + 1 == $past($countones(occ))))
    else $error("pipeline occupancy did not shrink on delivery");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (minx4_r <= maxx4_r) && (miny4_r <= maxy4_r))
    else $error("bounding box minimum exceeds maximum");

  a_point_extent: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !rect5_r) |-> (out5_r.out_w == '0) && (out5_r.out_h == '0))
    else $error("point result has nonzero extent");

endmodule

// ===== sim/affine_rect_bounding_box_core_tb.sv =====
`timescale 1ns / 100ps

module affine_rect_bounding_box_core_tb;
  import arbb_pkg::*;

  localparam int PIPE_LAT = 5;
  localparam int N_PHASES = 9;
  localparam int WORDS_PER_PHASE = 148;
  localparam longint CYCLE_LIMIT = 1000000;

  localparam logic signed [COEF_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic [DIM_W-1:0] U_MAX = 31'h7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] ONE = 32'sd65536;
  localparam logic signed [COEF_W-1:0] HALF = 32'sd32768;

  // Indexes past the last coefficient; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int KIND_IDENTITY = 0;
  localparam int KIND_SMALL = 1;
  localparam int KIND_FULL = 2;
  localparam int KIND_EXTREME = 3;
  localparam int KIND_ROTATE = 4;

  typedef logic signed [COEF_W-1:0] coef_set_t [6];

  typedef struct {
    int        setting;
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COEF_W-1:0] cfg_wdata;

  arbb_in_if in_ch ();
  arbb_out_if out_ch ();

  affine_rect_bounding_box_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  coef_set_t coef = '{ONE, 32'sd0, 32'sd0, 32'sd0, ONE, 32'sd0};
  out_word_t box_q [$];
  out_word_t want_box;
  int n_fail;
  int n_checked;
  int n_sent;
  int n_rect;
  int n_settings;
  int stall_pct = 25;
  bit no_idle;
  longint cycles;

  coef_set_t dir_coefs [4] = '{
    '{ONE, 32'sd0, 32'sd0, 32'sd0, ONE, 32'sd0},
    '{S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN},
    '{HALF, 32'sd0, 32'sd0, 32'sd0, -HALF, 32'sd0},
    '{32'sd0, -ONE, 100 * ONE, ONE, 32'sd0, -50 * ONE}
  };

  // Rows with typed set carry their result; the rest go through the predictor.
  dir_row_t dir_rows [22] = '{
    '{0, '{OP_POINT, 32'sd0, 32'sd0, 31'd0, 31'd0}, 1'b1, '{32'sd0, 32'sd0, 31'd0, 31'd0}},
    '{0, '{OP_POINT, S_MAX, S_MIN, U_MAX, U_MAX}, 1'b1, '{S_MAX, S_MIN, 31'd0, 31'd0}},
    '{0, '{OP_POINT, S_MIN, S_MAX, 31'd0, 31'd0}, 1'b1, '{S_MIN, S_MAX, 31'd0, 31'd0}},
    '{0, '{OP_RECT, S_MIN, S_MIN, U_MAX, U_MAX}, 1'b1, '{S_MIN, S_MIN, U_MAX, U_MAX}},
    '{0, '{OP_RECT, S_MAX, S_MAX, U_MAX, U_MAX}, 1'b1, '{S_MAX, S_MAX, U_MAX, U_MAX}},
    '{0, '{OP_RECT, -32'sd1, 32'sd1, 31'd0, 31'd0}, 1'b1, '{-32'sd1, 32'sd1, 31'd0, 31'd0}},
    '{0, '{OP_RECT, ONE, -ONE, 31'd327680, 31'd196608}, 1'b1,
         '{ONE, -ONE, 31'd327680, 31'd196608}},
    '{1, '{OP_POINT, S_MAX, S_MIN, 31'd0, 31'd0}, 1'b1, '{S_MAX, S_MIN, 31'd0, 31'd0}},
    '{1, '{OP_POINT, 32'sd0, 32'sd0, U_MAX, 31'd5}, 1'b1, '{S_MAX, S_MIN, 31'd0, 31'd0}},
    '{1, '{OP_RECT, S_MIN, S_MIN, U_MAX, U_MAX}, 1'b0, '{32'sd0, 32'sd0, 31'd0, 31'd0}},
    '{1, '{OP_RECT, 32'sd0, 32'sd0, 31'd65536, 31'd65536}, 1'b0,
         '{32'sd0, 32'sd0, 31'd0, 31'd0}},
    '{1, '{OP_RECT, S_MAX, 32'sd0, U_MAX, 31'd0}, 1'b0, '{32'sd0, 32'sd0, 31'd0, 31'd0}},
    '{2, '{OP_POINT, 32'sd1, 32'sd1, 31'd0, 31'd0}, 1'b1, '{32'sd1, 32'sd0, 31'd0, 31'd0}},
    '{2, '{OP_POINT, -32'sd1, -32'sd1, 31'd0, 31'd0}, 1'b1, '{32'sd0, 32'sd1, 31'd0, 31'd0}},
    '{2, '{OP_POINT, 32'sd3, -32'sd3, 31'd0, 31'd0}, 1'b1, '{32'sd2, 32'sd2, 31'd0, 31'd0}},
    '{2, '{OP_POINT, -32'sd3, 32'sd3, 31'd0, 31'd0}, 1'b1,
         '{-32'sd1, -32'sd1, 31'd0, 31'd0}},
    '{2, '{OP_RECT, 32'sd1, 32'sd1, 31'd2, 31'd2}, 1'b0, '{32'sd0, 32'sd0, 31'd0, 31'd0}},
    '{3, '{OP_POINT, ONE, 2 * ONE, 31'd0, 31'd0}, 1'b0, '{32'sd0, 32'sd0, 31'd0, 31'd0}},
    '{3, '{OP_RECT, ONE, 2 * ONE, 31'd262144, 31'd524288}, 1'b0,
         '{32'sd0, 32'sd0, 31'd0, 31'd0}},
    '{3, '{OP_RECT, S_MIN, S_MIN, U_MAX, U_MAX}, 1'b0, '{32'sd0, 32'sd0, 31'd0, 31'd0}},
    '{3, '{OP_RECT, S_MAX, S_MAX, U_MAX, U_MAX}, 1'b0, '{32'sd0, 32'sd0, 31'd0, 31'd0}},
    '{3, '{OP_POINT, S_MIN, S_MIN, U_MAX, 31'd0}, 1'b0, '{32'sd0, 32'sd0, 31'd0, 31'd0}}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Q16.16 product, rounded with halves going up.
  function automatic longint q16_product(logic signed [COEF_W-1:0] c, longint v);
    longint p;
    p = longint'(c) * v;
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [COEF_W-1:0] clamp_s32(longint v);
    if (v > 64'sd2147483647) return S_MAX;
    if (v < -64'sd2147483648) return S_MIN;
    return v[COEF_W-1:0];
  endfunction

  function automatic logic [DIM_W-1:0] clamp_u31(longint v);
    if (v > 64'sd2147483647) return U_MAX;
    if (v < 0) return '0;
    return v[DIM_W-1:0];
  endfunction

  function automatic out_word_t affine_box(in_word_t w);
    longint xs [4];
    longint ys [4];
    longint cx [4];
    longint cy [4];
    longint lo_x, hi_x, lo_y, hi_y;
    out_word_t r;
    xs[0] = longint'(w.in_x);
    ys[0] = longint'(w.in_y);
    xs[1] = xs[0] + longint'(w.in_w);
    ys[1] = ys[0];
    xs[2] = xs[0];
    ys[2] = ys[0] + longint'(w.in_h);
    xs[3] = xs[1];
    ys[3] = ys[2];
    for (int i = 0; i < 4; i++) begin
      cx[i] = q16_product(coef[CFG_XX], xs[i]) + q16_product(coef[CFG_XY], ys[i])
              + longint'(coef[CFG_XT]);
      cy[i] = q16_product(coef[CFG_YX], xs[i]) + q16_product(coef[CFG_YY], ys[i])
              + longint'(coef[CFG_YT]);
    end
    if (w.op == OP_POINT) begin
      r.out_x = clamp_s32(cx[0]);
      r.out_y = clamp_s32(cy[0]);
      r.out_w = '0;
      r.out_h = '0;
      return r;
    end
    lo_x = cx[0];
    hi_x = cx[0];
    lo_y = cy[0];
    hi_y = cy[0];
    for (int i = 1; i < 4; i++) begin
      if (cx[i] < lo_x) lo_x = cx[i];
      if (cx[i] > hi_x) hi_x = cx[i];
      if (cy[i] < lo_y) lo_y = cy[i];
      if (cy[i] > hi_y) hi_y = cy[i];
    end
    // The extent comes from the unclamped corner sums, not from out_x and out_y.
    r.out_x = clamp_s32(lo_x);
    r.out_y = clamp_s32(lo_y);
    r.out_w = clamp_u31(hi_x - lo_x);
    r.out_h = clamp_u31(hi_y - lo_y);
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] pick_extreme();
    case ($urandom_range(0, 6))
      0: return S_MAX;
      1: return S_MIN;
      2: return ONE;
      3: return -ONE;
      4: return 32'sd1;
      5: return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return int'($urandom_range(0, 134217728)) - 67108864;
    if (r < 85) return $urandom;
    return pick_extreme();
  endfunction

  function automatic logic [DIM_W-1:0] rand_extent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return DIM_W'($urandom_range(0, 67108864));
    if (r < 85) return DIM_W'($urandom);
    case ($urandom_range(0, 2))
      0: return '0;
      1: return 31'd1;
      default: return U_MAX;
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.op = op_e'($urandom_range(0, 1));
    w.in_x = rand_coord();
    w.in_y = rand_coord();
    w.in_w = rand_extent();
    w.in_h = rand_extent();
    return w;
  endfunction

  task automatic pick_coefs(input int kind, output coef_set_t c);
    logic signed [COEF_W-1:0] cs, sn;
    cs = int'($urandom_range(0, 131072)) - 65536;
    sn = int'($urandom_range(0, 131072)) - 65536;
    case (kind)
      KIND_IDENTITY: c = '{ONE, 32'sd0, 32'sd0, 32'sd0, ONE, 32'sd0};
      KIND_SMALL:
        for (int i = CFG_XX; i <= CFG_YT; i++) c[i] = int'($urandom_range(0, 524288)) - 262144;
      KIND_FULL:
        for (int i = CFG_XX; i <= CFG_YT; i++) c[i] = $urandom;
      KIND_EXTREME:
        for (int i = CFG_XX; i <= CFG_YT; i++) c[i] = pick_extreme();
      KIND_ROTATE: begin
        c[CFG_XX] = cs;
        c[CFG_XY] = -sn;
        c[CFG_YX] = sn;
        c[CFG_YY] = cs;
        c[CFG_XT] = int'($urandom_range(0, 536870912)) - 268435456;
        c[CFG_YT] = int'($urandom_range(0, 536870912)) - 268435456;
      end
      default: c = '{ONE, 32'sd0, 32'sd0, 32'sd0, ONE, 32'sd0};
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input in_word_t w, input out_word_t want);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    box_q.push_back(want);
    n_sent++;
    if (w.op == OP_RECT) n_rect++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (box_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic apply_coefs(input coef_set_t c);
    drain_results();
    for (int i = CFG_XX; i <= CFG_YT; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= CFG_IDX_W'(i);
      cfg_wdata <= c[i];
      @(posedge clk);
      coef[i] = c[i];
    end
    cfg_idx <= CFG_SPARE_LO;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_idx <= CFG_SPARE_HI;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Result side: random stalls, mostly short, now and then long.
  initial begin
    int r;
    int stall_left;
    out_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (no_idle || r >= stall_pct) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = (r < 2) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (box_q.size() == 0) begin
        $error("result word with nothing expected: x=%0d y=%0d w=%0d h=%0d",
               out_ch.data.out_x, out_ch.data.out_y, out_ch.data.out_w, out_ch.data.out_h);
        n_fail++;
      end else begin
        want_box = box_q.pop_front();
        n_checked++;
        if (out_ch.data.out_x !== want_box.out_x) begin
          $error("out_x: expected %0d, got %0d", want_box.out_x, out_ch.data.out_x);
          n_fail++;
        end
        if (out_ch.data.out_y !== want_box.out_y) begin
          $error("out_y: expected %0d, got %0d", want_box.out_y, out_ch.data.out_y);
          n_fail++;
        end
        if (out_ch.data.out_w !== want_box.out_w) begin
          $error("out_w: expected %0d, got %0d", want_box.out_w, out_ch.data.out_w);
          n_fail++;
        end
        if (out_ch.data.out_h !== want_box.out_h) begin
          $error("out_h: expected %0d, got %0d", want_box.out_h, out_ch.data.out_h);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, box_q.size());
      $display("FAIL affine_rect_bounding_box_core");
      $finish;
    end
  end

  initial begin
    int setting;
    coef_set_t c;
    in_word_t rw;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words; the first rows run on the coefficients left by reset.
    setting = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].setting != setting) begin
        setting = dir_rows[i].setting;
        apply_coefs(dir_coefs[setting]);
      end
      send_word(dir_rows[i].word,
                dir_rows[i].typed ? dir_rows[i].want : affine_box(dir_rows[i].word));
    end

    for (int p = 0; p < N_PHASES; p++) begin
      pick_coefs(p % 5, c);
      apply_coefs(c);
      no_idle = (p == 2);
      stall_pct = (p == 6) ? 60 : 25;
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // Let the pipeline empty completely once in the middle of a stream.
        if (p == 4 && i == WORDS_PER_PHASE / 2) drain_results();
        rw = rand_word();
        send_word(rw, affine_box(rw));
      end
    end

    in_ch.valid <= 1'b0;
    while (box_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT * 4) @(posedge clk);

    $display("Sent %0d words (%0d rectangles) under %0d coefficient settings,",
             n_sent, n_rect, n_settings + 1);
    $display("%0d results checked; covered saturation, half rounding, spare register writes",
             n_checked);
    $display("and stalls on both sides.");
    if (n_fail == 0 && box_q.size() == 0) begin
      $display("PASS affine_rect_bounding_box_core");
    end else begin
      $display("FAIL affine_rect_bounding_box_core");
    end
    $finish;
  end

endmodule
